// ===== rtl/tor_pkg.sv =====
// Telnet option receiver package: byte codes, phase and action types, and the
// command word passed from front end to back end. No dependencies.
`default_nettype none

package tor_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] B_IAC    = 8'd255;
   localparam logic [7:0] B_DONT   = 8'd254;
   localparam logic [7:0] B_DO     = 8'd253;
   localparam logic [7:0] B_WONT   = 8'd252;
   localparam logic [7:0] B_WILL   = 8'd251;
   localparam logic [7:0] B_DM     = 8'd242;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   localparam logic [1:0] KIND_TERM  = 2'd0;
   localparam logic [1:0] KIND_NET   = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   typedef enum logic [2:0] {
      PH_DATA = 3'd0,
      PH_IAC  = 3'd1,
      PH_WILL = 3'd2,
      PH_WONT = 3'd3,
      PH_DO   = 3'd4,
      PH_DONT = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ACT_TERM  = 2'd0,
      ACT_FLUSH = 2'd1,
      ACT_REPLY = 2'd2
   } action_type;

   typedef struct packed {
      action_type action;
      logic [7:0] data;
      logic [7:0] verb;
      logic       echo;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== rtl/tor_front.sv =====
// Front end: telnet receive phase machine, option marks and echo mode.
// Classifies each byte into a command word. Uses tor_pkg.
`default_nettype none

module tor_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   output tor_pkg::cmd_type      cmd,
   output logic                  cmd_valid
);
   import tor_pkg::*;

   phase_type phase_ff, phase_in;
   logic      en_echo_ff, en_echo_in;
   logic      en_sga_ff, en_sga_in;
   logic      echo_ff, echo_in;

   // only ECHO and SGA can ever be marked enabled; all other marks stay clear
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_IAC: begin
               if (in_byte == B_WILL)      phase_in = PH_WILL;
               else if (in_byte == B_WONT) phase_in = PH_WONT;
               else if (in_byte == B_DO)   phase_in = PH_DO;
               else if (in_byte == B_DONT) phase_in = PH_DONT;
               else                        phase_in = PH_DATA;
            end
            PH_WILL, PH_WONT, PH_DO, PH_DONT: phase_in = PH_DATA;
            default: begin
               phase_in = (in_byte == B_IAC) ? PH_IAC : PH_DATA;
            end
         endcase
      end
   end

   always_comb begin
      logic valid;
      action_type act;
      logic [7:0] verb;
      valid      = 1'b0;
      act        = ACT_TERM;
      verb       = B_DO;
      en_echo_in = en_echo_ff;
      en_sga_in  = en_sga_ff;
      echo_in    = echo_ff;
      case (phase_ff)
         PH_IAC: begin
            if (in_byte == B_DM) begin
               valid = 1'b1;
               act   = ACT_FLUSH;
            end
         end
         PH_WILL: begin
            act = ACT_REPLY;
            if (in_byte == OPT_ECHO) begin
               if (!en_echo_ff) begin
                  valid      = 1'b1;
                  verb       = B_DO;
                  en_echo_in = 1'b1;
                  echo_in    = 1'b0;
               end
            end else if (in_byte == OPT_SGA) begin
               if (!en_sga_ff) begin
                  valid     = 1'b1;
                  verb      = B_DO;
                  en_sga_in = 1'b1;
               end
            end else begin
               valid = 1'b1;
               verb  = B_DONT;
            end
         end
         PH_WONT: begin
            act  = ACT_REPLY;
            verb = B_DONT;
            if (in_byte == OPT_ECHO && en_echo_ff) begin
               valid      = 1'b1;
               en_echo_in = 1'b0;
               echo_in    = 1'b1;
            end else if (in_byte == OPT_SGA && en_sga_ff) begin
               valid     = 1'b1;
               en_sga_in = 1'b0;
            end
         end
         PH_DO: begin
            act   = ACT_REPLY;
            valid = 1'b1;
            if (in_byte == OPT_SGA) begin
               verb = B_WILL;
            end else if (in_byte == OPT_ECHO) begin
               verb       = B_WILL;
               echo_in    = 1'b1;
               en_echo_in = 1'b0;
            end else begin
               verb = B_WONT;
            end
         end
         PH_DONT: valid = 1'b0;
         default: begin
            if (in_byte != B_IAC) begin
               valid = 1'b1;
               act   = ACT_TERM;
            end
         end
      endcase
      cmd_valid  = accept && valid;
      cmd.action = act;
      cmd.data   = (act == ACT_FLUSH) ? 8'd0 : in_byte;
      cmd.verb   = verb;
      cmd.echo   = echo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DATA;
         en_echo_ff <= 1'b0;
         en_sga_ff  <= 1'b0;
         echo_ff    <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            en_echo_ff <= en_echo_in;
            en_sga_ff  <= en_sga_in;
            echo_ff    <= echo_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tor_queue.sv =====
// Command queue between front and back end: small register FIFO.
// Uses tor_pkg for the command word and status struct.
`default_nettype none

module tor_queue #(
   parameter int DEPTH = tor_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tor_pkg::cmd_type     push_cmd,
   input  wire logic                 pop,
   output tor_pkg::cmd_type          head,
   output tor_pkg::q_status_type     status
);
   import tor_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tor_back.sv =====
// Back end: expands queued commands into result words, three beats for a
// reply, and holds them in the output register. Uses tor_pkg.
`default_nettype none

module tor_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tor_pkg::cmd_type     head,
   input  wire tor_pkg::q_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last,
   output logic                      rsp_echo_local
);
   import tor_pkg::*;

   localparam logic [1:0] BEAT_IAC  = 2'd0;
   localparam logic [1:0] BEAT_VERB = 2'd1;

   logic [1:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       echo_ff, echo_in;
   logic       load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      kind_in = KIND_TERM;
      byte_in = head.data;
      last_in = 1'b1;
      echo_in = head.echo;
      case (head.action)
         ACT_FLUSH: begin
            kind_in = KIND_FLUSH;
            byte_in = 8'd0;
         end
         ACT_REPLY: begin
            kind_in = KIND_NET;
            case (beat_ff)
               BEAT_IAC:  byte_in = B_IAC;
               BEAT_VERB: byte_in = head.verb;
               default:   byte_in = head.data;
            endcase
            last_in = (beat_ff != BEAT_IAC) && (beat_ff != BEAT_VERB);
         end
         default: kind_in = KIND_TERM;
      endcase
      valid_in = valid_ff;
      beat_in  = beat_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (last_in) begin
               pop     = 1'b1;
               beat_in = BEAT_IAC;
            end else begin
               beat_in = beat_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= BEAT_IAC;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
         echo_ff <= echo_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_last       = last_ff;
   assign rsp_echo_local = echo_ff;

endmodule

`default_nettype wire

// ===== rtl/telnet_option_receiver_top.sv =====
// Telnet option receiver top level: front end, command queue, back end.
// Depends on tor_pkg, tor_front, tor_queue and tor_back.
//
// Takes one network byte per cycle while the command queue has room. Each byte
// gives none, one or three result words; a data byte or flush gives one word, a
// negotiation reply gives three words in turn, paced by the back end's beat
// counter. The first result word passes through the command queue and then the
// back end's output register. Input stalls only when QUEUE_DEPTH commands wait,
// which happens only when replies outpace the back end or the result side stalls.
`default_nettype none

module telnet_option_receiver_top #(
   parameter int QUEUE_DEPTH = tor_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last,
   output logic            rsp_echo_local
);
   import tor_pkg::*;

   cmd_type      front_cmd;
   logic         front_valid;
   cmd_type      q_head;
   q_status_type q_status;
   logic         q_pop;
   logic         accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   tor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .cmd       (front_cmd),
      .cmd_valid (front_valid)
   );

   tor_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   tor_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_status       (q_status),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_echo_local (rsp_echo_local)
   );

endmodule

`default_nettype wire

// ===== rtl/tor_checker.sv =====
// Port-level checks for the telnet option receiver, bound to the top level.
// Uses tor_pkg for result kind codes.
`default_nettype none

module tor_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_in_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       rsp_echo_local
);
   import tor_pkg::*;

   logic reply_mid;
   assign reply_mid = rsp_valid && !rsp_stall && rsp_kind == KIND_NET && !rsp_last;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled input word changed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind))
      else $error("stalled result word changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid straight after reset");

   a_reply_burst: assert property (@(posedge clock) disable iff (reset)
      reply_mid |=> rsp_valid && rsp_kind == KIND_NET)
      else $error("reply burst broken");

   a_reply_echo: assert property (@(posedge clock) disable iff (reset)
      reply_mid |=> rsp_echo_local == $past(rsp_echo_local))
      else $error("echo mode changed within a reply");

endmodule

bind telnet_option_receiver_top tor_checker u_tor_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_telnet_option_receiver_top.sv =====
// Self-checking bench for telnet_option_receiver_top: directed and random byte
// streams with random idling on both sides, checked against a local predictor.
// Depends on tor_pkg and the telnet_option_receiver_top RTL.

module tb_telnet_option_receiver_top;
   import tor_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 330;
   localparam int HOLD_CYCLES  = 80;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       echo;
   } rx_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_echo_local;

   // predictor state
   phase_type   rx_state;
   logic        remote_on [256];
   logic        echo_mode;
   rx_word_type expected_words [$];

   int         error_count = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         input_stalls = 0;
   int         term_words = 0;
   int         net_words = 0;
   int         flush_words = 0;
   bit         tx_idling = 1'b1;
   bit         rsp_idling = 1'b1;
   int         hold_request = 0;
   int         stall_left = 0;

   telnet_option_receiver_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_echo_local (rsp_echo_local)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out, %0d words outstanding", $time, expected_words.size());
         $display("[telnet_option_receiver_top] ERROR");
         $finish;
      end
   end

   // result side stall: random wait per word, or a long hold on request
   always @(posedge clock) begin : rsp_stall_driver
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_request != 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (rsp_valid && !rsp_stall && rsp_idling) begin
            stall_left = $urandom_range(0, 5);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_checker
      rx_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got kind %0d byte %02h",
                     $time, rsp_kind, rsp_out_byte);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", int'(want.kind), int'(rsp_kind));
            check_field("out_byte", int'(want.data), int'(rsp_out_byte));
            check_field("last", int'(want.last), int'(rsp_last));
            check_field("echo_local", int'(want.echo), int'(rsp_echo_local));
            case (want.kind)
               KIND_TERM:  term_words++;
               KIND_NET:   net_words++;
               default:    flush_words++;
            endcase
         end
      end
   end

   task automatic predict_byte(input logic [7:0] c);
      rx_word_type w [3];
      logic [7:0]  verb;
      phase_type   ph;
      int          n;
      ph = rx_state;
      rx_state = PH_DATA;
      n = 0;
      verb = B_DONT;
      case (ph)
         PH_IAC: begin
            if (c == B_WILL) rx_state = PH_WILL;
            else if (c == B_WONT) rx_state = PH_WONT;
            else if (c == B_DO) rx_state = PH_DO;
            else if (c == B_DONT) rx_state = PH_DONT;
            else if (c == B_DM) begin
               w[0].kind = KIND_FLUSH;
               w[0].data = 8'h00;
               n = 1;
            end
         end
         PH_WILL: begin
            if (!remote_on[c]) begin
               if (c == OPT_ECHO || c == OPT_SGA) begin
                  if (c == OPT_ECHO) echo_mode = 1'b0;
                  remote_on[c] = 1'b1;
                  verb = B_DO;
               end else begin
                  verb = B_DONT;
               end
               n = 3;
            end
         end
         PH_WONT: begin
            if (remote_on[c]) begin
               if (c == OPT_ECHO || c == OPT_SGA) begin
                  if (c == OPT_ECHO) echo_mode = 1'b1;
                  remote_on[c] = 1'b0;
               end
               verb = B_DONT;
               n = 3;
            end
         end
         PH_DO: begin
            if (c == OPT_SGA) begin
               verb = B_WILL;
            end else if (c == OPT_ECHO) begin
               echo_mode = 1'b1;
               remote_on[c] = 1'b0;
               verb = B_WILL;
            end else begin
               verb = B_WONT;
            end
            n = 3;
         end
         PH_DONT: ;
         default: begin
            if (c == B_IAC) rx_state = PH_IAC;
            else begin
               w[0].kind = KIND_TERM;
               w[0].data = c;
               n = 1;
            end
         end
      endcase
      if (n == 3) begin
         w[0].kind = KIND_NET;
         w[0].data = B_IAC;
         w[1].kind = KIND_NET;
         w[1].data = verb;
         w[2].kind = KIND_NET;
         w[2].data = c;
      end
      for (int k = 0; k < n; k++) begin
         w[k].echo = echo_mode;
         w[k].last = (k == n - 1);
         expected_words.push_back(w[k]);
      end
   endtask

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_idling ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
         if (req_stall) input_stalls++;
      end while (req_stall);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic send_command(input logic [7:0] verb, input logic [7:0] opt);
      send_byte(B_IAC);
      send_byte(verb);
      send_byte(opt);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(0, 7))
         0, 1, 2: return OPT_ECHO;
         3, 4:    return OPT_SGA;
         5:       return 8'h00;
         6:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_verb();
      case ($urandom_range(0, 3))
         0:       return B_WILL;
         1:       return B_WONT;
         2:       return B_DO;
         default: return B_DONT;
      endcase
   endfunction

   // one well-formed sequence most of the time, otherwise noise
   task automatic send_sequence();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_byte(8'($urandom_range(0, 254)));
      end else if (pick < 85) begin
         send_command(pick_verb(), pick_option());
      end else if (pick < 95) begin
         send_byte(B_IAC);
         case ($urandom_range(0, 4))
            0: send_byte(B_IAC);
            1: send_byte(B_DM);
            2: send_byte(8'd241);
            3: send_byte(8'd249);
            default: send_byte(8'($urandom_range(0, 250)));
         endcase
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFE);
      send_byte(B_IAC);
      send_byte(B_DM);
      send_byte(B_IAC);
      send_byte(B_IAC);
      send_command(B_WILL, OPT_ECHO);
      send_command(B_WILL, OPT_ECHO);     // already enabled: silent
      send_command(B_WILL, 8'h00);
      send_command(B_WONT, OPT_ECHO);
      send_command(B_DO, 8'hFF);
      send_command(B_DONT, 8'h55);
      wait_drained();
   endtask

   task automatic test_random_stream();
      int target;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 39) == 0) begin
            tx_idling = $urandom_range(0, 2) != 0;
            rsp_idling = $urandom_range(0, 2) != 0;
         end
         send_sequence();
      end
      tx_idling = 1'b1;
      rsp_idling = 1'b1;
      wait_drained();
   endtask

   // long result hold while the sender keeps going, so the input stalls
   task automatic test_backpressure();
      tx_idling = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (20) send_command(B_DO, pick_option());
      tx_idling = 1'b1;
      wait_drained();
   endtask

   // sender pauses mid-stream until every word is out
   task automatic test_drain_pause();
      repeat (5) send_sequence();
      send_command(B_WILL, OPT_SGA);
      wait_drained();
      send_command(B_WONT, OPT_SGA);
      send_command(B_DO, OPT_ECHO);
      repeat (5) send_sequence();
      wait_drained();
   endtask

   initial begin
      rx_state = PH_DATA;
      echo_mode = 1'b1;
      foreach (remote_on[i]) remote_on[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_stream();
      test_backpressure();
      test_drain_pause();
      $display("Covered %0d input bytes, %0d input stall cycles.", bytes_sent, input_stalls);
      $display("Checked %0d terminal, %0d reply and %0d flush words.",
               term_words, net_words, flush_words);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("[telnet_option_receiver_top] OK");
      end else begin
         $display("[telnet_option_receiver_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== telnet_option_receiver_top.f =====
rtl/tor_pkg.sv
rtl/tor_front.sv
rtl/tor_queue.sv
rtl/tor_back.sv
rtl/telnet_option_receiver_top.sv
rtl/tor_checker.sv
tb/sv/tb_telnet_option_receiver_top.sv
